### hdl/ppts_pkg.sv
// Package for the preemptive priority task scheduler.
// Heap entry and result types, sequencer states and ordering function.
// No dependencies.
`default_nettype none
package ppts_pkg;

   localparam int ENT_W = 88;

   localparam logic ACT_ARRIVE = 1'b0;
   localparam logic ACT_DRAIN  = 1'b1;

   localparam logic RES_DONE   = 1'b0;
   localparam logic RES_REJECT = 1'b1;

   typedef struct packed {
      logic [15:0] task_id;
      logic [31:0] arrival;
      logic [31:0] remaining;
      logic [7:0]  prio;
   } ent_type;

   typedef struct packed {
      logic        emit;
      logic        flush;
      logic [15:0] id;
      logic [31:0] fin;
      logic        status;
   } res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TOP_RD,
      ST_TOP_CHK,
      ST_DEL_RD,
      ST_DEL_LATCH,
      ST_SD_L,
      ST_SD_R,
      ST_SD_R2,
      ST_SD_CMP,
      ST_INS,
      ST_INS_L,
      ST_INS_R,
      ST_FINISH
   } state_type;

   // true when a must run ahead of b
   function automatic logic runs_before(ent_type a, ent_type b);
      logic r;
      if (a.prio != b.prio) begin
         r = (a.prio > b.prio);
      end else begin
         r = (a.arrival < b.arrival);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### hdl/preemptive_priority_task_scheduler_unit.sv
// Channel   | ports                                   | handshake
// request   | req_action/task_id/arrival_time/...     | start & !busy
// result    | rsp_done_id/finish_time/status/last     | rsp_valid, one cycle
// Completed tasks walk the heap down and inserts walk it up, one level at a
// time, paced by the single heap RAM read port with its registered read.
// Reset clears count and time; heap contents need no clearing pass.
// Results cannot be stalled; busy stays high until the item is finished.
// Depends on ppts_pkg, ppts_ram, ppts_rsp.
`default_nettype none
module preemptive_priority_task_scheduler_unit #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_action,
   input  wire logic [15:0] req_task_id,
   input  wire logic [31:0] req_arrival_time,
   input  wire logic [31:0] req_run_time,
   input  wire logic [7:0]  req_priority_req,
   output logic             rsp_valid,
   output logic [15:0]      rsp_done_id,
   output logic [31:0]      rsp_finish_time,
   output logic             rsp_status,
   output logic             rsp_last_result
);
   import ppts_pkg::*;

   localparam int AW  = $clog2(QUEUE_DEPTH);
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int CW1 = CW + 1;

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, n_ff, n_in;
   logic [31:0] time_ff, time_in, elapsed_ff, elapsed_in;
   logic        drain_ff, drain_in;
   ent_type     new_ff, new_in, x_ff, x_in, b_ff, b_in;
   logic [AW-1:0] p_ff, p_in, bidx_ff, bidx_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   ent_type       wr_data, rd_ent;
   logic [ENT_W-1:0] rd_raw;
   res_type       res;

   logic [CW1-1:0] c_w, c1_w;
   logic [AW-1:0]  parent;
   logic [CW-1:0]  count_m1;
   logic [31:0]    top_fin;

   assign rd_ent   = ent_type'(rd_raw);
   assign c_w      = CW1'({p_ff, 1'b0}) + CW1'(1);
   assign c1_w     = c_w + CW1'(1);
   assign parent   = AW'((p_ff - AW'(1)) >> 1);
   assign count_m1 = count_ff - CW'(1);
   assign top_fin  = time_ff + rd_ent.remaining;

   ppts_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_heap (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_raw)
   );

   ppts_rsp u_rsp (
      .clock(clock), .reset(reset), .res(res),
      .rsp_valid(rsp_valid), .rsp_done_id(rsp_done_id),
      .rsp_finish_time(rsp_finish_time), .rsp_status(rsp_status),
      .rsp_last_result(rsp_last_result)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (start) state_in = ST_TOP_RD;
         ST_TOP_RD: begin
            if (count_ff != '0) state_in = ST_TOP_CHK;
            else if (drain_ff == ACT_DRAIN) state_in = ST_FINISH;
            else state_in = ST_INS;
         end
         ST_TOP_CHK: begin
            if (drain_ff == ACT_DRAIN || rd_ent.remaining <= elapsed_ff)
               state_in = ST_DEL_RD;
            else state_in = ST_INS;
         end
         ST_DEL_RD:    state_in = (count_m1 == '0) ? ST_TOP_RD : ST_DEL_LATCH;
         ST_DEL_LATCH: state_in = ST_SD_L;
         ST_SD_L:      state_in = (c_w >= CW1'(n_ff)) ? ST_TOP_RD : ST_SD_R;
         ST_SD_R:      state_in = (c1_w < CW1'(n_ff)) ? ST_SD_R2 : ST_SD_CMP;
         ST_SD_R2:     state_in = ST_SD_CMP;
         ST_SD_CMP:    state_in = runs_before(b_ff, x_ff) ? ST_SD_L : ST_TOP_RD;
         ST_INS:       state_in = (count_ff >= CW'(QUEUE_DEPTH)) ? ST_FINISH : ST_INS_L;
         ST_INS_L:     state_in = (p_ff == '0) ? ST_FINISH : ST_INS_R;
         ST_INS_R:     state_in = runs_before(x_ff, rd_ent) ? ST_INS_L : ST_FINISH;
         ST_FINISH:    state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in   = count_ff;
      n_in       = n_ff;
      time_in    = time_ff;
      elapsed_in = elapsed_ff;
      drain_in   = drain_ff;
      new_in     = new_ff;
      x_in       = x_ff;
      b_in       = b_ff;
      p_in       = p_ff;
      bidx_in    = bidx_ff;
      wr_en      = 1'b0;
      wr_addr    = p_ff;
      wr_data    = x_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      res        = '{emit: 1'b0, flush: 1'b0, id: rd_ent.task_id, fin: top_fin,
                     status: RES_DONE};
      unique case (state_ff)
         ST_IDLE: begin
            drain_in = req_action;
            new_in   = '{task_id: req_task_id, arrival: req_arrival_time,
                         remaining: req_run_time, prio: req_priority_req};
            elapsed_in = (req_arrival_time >= time_ff) ?
                         (req_arrival_time - time_ff) : 32'd0;
         end
         ST_TOP_RD: begin
            if (count_ff != '0) begin
               rd_en = 1'b1;
            end else if (drain_ff == ACT_ARRIVE) begin
               time_in = time_ff + elapsed_ff;
            end
         end
         ST_TOP_CHK: begin
            if (drain_ff == ACT_DRAIN || rd_ent.remaining <= elapsed_ff) begin
               res.emit = 1'b1;
               time_in  = top_fin;
               if (drain_ff == ACT_ARRIVE) elapsed_in = elapsed_ff - rd_ent.remaining;
            end else begin
               wr_en   = 1'b1;
               wr_addr = '0;
               wr_data = rd_ent;
               wr_data.remaining = rd_ent.remaining - elapsed_ff;
               time_in = time_ff + elapsed_ff;
            end
         end
         ST_DEL_RD: begin
            count_in = count_m1;
            n_in     = count_m1;
            rd_en    = (count_m1 != '0);
            rd_addr  = count_m1[AW-1:0];
         end
         ST_DEL_LATCH: begin
            x_in = rd_ent;
            p_in = '0;
         end
         ST_SD_L: begin
            if (c_w >= CW1'(n_ff)) begin
               wr_en = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = c_w[AW-1:0];
            end
         end
         ST_SD_R: begin
            b_in    = rd_ent;
            bidx_in = c_w[AW-1:0];
            if (c1_w < CW1'(n_ff)) begin
               rd_en   = 1'b1;
               rd_addr = c1_w[AW-1:0];
            end
         end
         ST_SD_R2: begin
            if (runs_before(rd_ent, b_ff)) begin
               b_in    = rd_ent;
               bidx_in = c1_w[AW-1:0];
            end
         end
         ST_SD_CMP: begin
            wr_en = 1'b1;
            if (runs_before(b_ff, x_ff)) begin
               wr_data = b_ff;
               p_in    = bidx_ff;
            end
         end
         ST_INS: begin
            if (count_ff >= CW'(QUEUE_DEPTH)) begin
               res.emit   = 1'b1;
               res.id     = new_ff.task_id;
               res.fin    = '0;
               res.status = RES_REJECT;
            end else begin
               p_in     = count_ff[AW-1:0];
               count_in = count_ff + CW'(1);
               x_in     = new_ff;
            end
         end
         ST_INS_L: begin
            if (p_ff == '0) begin
               wr_en = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = parent;
            end
         end
         ST_INS_R: begin
            wr_en = 1'b1;
            if (runs_before(x_ff, rd_ent)) begin
               wr_data = rd_ent;
               p_in    = parent;
            end
         end
         ST_FINISH: res.flush = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         time_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         time_ff  <= time_in;
      end
      n_ff       <= n_in;
      elapsed_ff <= elapsed_in;
      drain_ff   <= drain_in;
      new_ff     <= new_in;
      x_ff       <= x_in;
      b_ff       <= b_in;
      p_ff       <= p_in;
      bidx_ff    <= bidx_in;
   end

   assign busy = (state_ff != ST_IDLE);

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH)) else $error("queue count beyond depth");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item not taken up");
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !$past(state_ff == ST_IDLE)))
      else $error("result without work in progress");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !wr_en) else $error("heap written while idle");

endmodule
`default_nettype wire

### hdl/ppts_ram.sv
// Generic single write, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module ppts_ram #(
   parameter int WIDTH = 88,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### hdl/ppts_rsp.sv
// Result stage: holds one result back so the final transfer of an item is marked.
// Depends on ppts_pkg.
`default_nettype none
module ppts_rsp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ppts_pkg::res_type res,
   output logic                  rsp_valid,
   output logic [15:0]           rsp_done_id,
   output logic [31:0]           rsp_finish_time,
   output logic                  rsp_status,
   output logic                  rsp_last_result
);
   import ppts_pkg::*;

   logic        pend_valid_ff, pend_valid_in;
   logic [15:0] pend_id_ff, pend_id_in;
   logic [31:0] pend_fin_ff, pend_fin_in;
   logic        pend_st_ff, pend_st_in;
   logic        out_valid_ff, out_valid_in;
   logic        out_last_ff, out_last_in;
   logic [15:0] out_id_ff;
   logic [31:0] out_fin_ff;
   logic        out_st_ff;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_fin_in   = pend_fin_ff;
      pend_st_in    = pend_st_ff;
      out_valid_in  = 1'b0;
      out_last_in   = 1'b0;
      priority if (res.emit) begin
         out_valid_in  = pend_valid_ff;
         pend_valid_in = 1'b1;
         pend_id_in    = res.id;
         pend_fin_in   = res.fin;
         pend_st_in    = res.status;
      end else if (res.flush) begin
         out_valid_in  = pend_valid_ff;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_id_ff  <= pend_id_in;
      pend_fin_ff <= pend_fin_in;
      pend_st_ff  <= pend_st_in;
      out_last_ff <= out_last_in;
      out_id_ff   <= pend_id_ff;
      out_fin_ff  <= pend_fin_ff;
      out_st_ff   <= pend_st_ff;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_done_id     = out_id_ff;
   assign rsp_finish_time = out_fin_ff;
   assign rsp_status      = out_st_ff;
   assign rsp_last_result = out_last_ff;

endmodule
`default_nettype wire

### tb/sv/preemptive_priority_task_scheduler_unit_test.sv
// Testbench for preemptive_priority_task_scheduler_unit: a queue-fed driver and a monitor
// check every completion and rejection against a heap-based scheduler predictor.
// Depends on ppts_pkg and the scheduler RTL.
`timescale 1ns / 100ps
`default_nettype none
module preemptive_priority_task_scheduler_unit_test;
   import ppts_pkg::*;

   localparam int DEPTH = 64;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      logic        action;
      logic [15:0] task_id;
      logic [31:0] arrival;
      logic [31:0] run;
      logic [7:0]  prio;
   } task_req_type;

   typedef struct {
      logic [15:0] id;
      logic [31:0] fin;
      logic        status;
      logic        last;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_action = 1'b0;
   logic [15:0] req_task_id = '0;
   logic [31:0] req_arrival_time = '0;
   logic [31:0] req_run_time = '0;
   logic [7:0]  req_priority_req = '0;
   logic        rsp_valid;
   logic [15:0] rsp_done_id;
   logic [31:0] rsp_finish_time;
   logic        rsp_status;
   logic        rsp_last_result;

   task_req_type pending_tasks[$];
   outcome_type  awaited_results[$];
   int        errors = 0;
   int        sent = 0;
   int        total_items = 0;
   int        cycles = 0;
   bit        took = 1'b0;

   ent_type     ready_heap[DEPTH];
   int          heap_size = 0;
   logic [31:0] sched_time = '0;

   preemptive_priority_task_scheduler_unit #(.QUEUE_DEPTH(DEPTH)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_task_id(req_task_id),
      .req_arrival_time(req_arrival_time), .req_run_time(req_run_time),
      .req_priority_req(req_priority_req), .rsp_valid(rsp_valid),
      .rsp_done_id(rsp_done_id), .rsp_finish_time(rsp_finish_time),
      .rsp_status(rsp_status), .rsp_last_result(rsp_last_result)
   );

   always #5 clock = ~clock;

   function automatic bit ahead(ent_type a, ent_type b);
      if (a.prio != b.prio) return a.prio > b.prio;
      return a.arrival < b.arrival;
   endfunction

   task automatic heap_push(ent_type e);
      int p;
      int par;
      ent_type t;
      p = heap_size;
      ready_heap[p] = e;
      heap_size++;
      while (p > 0) begin
         par = (p - 1) / 2;
         if (!ahead(ready_heap[p], ready_heap[par])) break;
         t = ready_heap[p]; ready_heap[p] = ready_heap[par]; ready_heap[par] = t;
         p = par;
      end
   endtask

   task automatic heap_pop();
      int p;
      int c;
      ent_type t;
      p = 0;
      heap_size--;
      if (heap_size == 0) return;
      ready_heap[0] = ready_heap[heap_size];
      forever begin
         c = 2 * p + 1;
         if (c >= heap_size) break;
         if (c + 1 < heap_size && ahead(ready_heap[c + 1], ready_heap[c])) c++;
         if (!ahead(ready_heap[c], ready_heap[p])) break;
         t = ready_heap[c]; ready_heap[c] = ready_heap[p]; ready_heap[p] = t;
         p = c;
      end
   endtask

   task automatic schedule_item(task_req_type it);
      outcome_type res[$];
      outcome_type o;
      logic [31:0] elapsed;
      ent_type     e;
      if (it.action == ACT_DRAIN) begin
         while (heap_size > 0) begin
            sched_time += ready_heap[0].remaining;
            o = '{ready_heap[0].task_id, sched_time, RES_DONE, 1'b0};
            res.push_back(o);
            heap_pop();
         end
      end else begin
         elapsed = (it.arrival >= sched_time) ? it.arrival - sched_time : '0;
         while (heap_size > 0 && ready_heap[0].remaining <= elapsed) begin
            sched_time += ready_heap[0].remaining;
            elapsed -= ready_heap[0].remaining;
            o = '{ready_heap[0].task_id, sched_time, RES_DONE, 1'b0};
            res.push_back(o);
            heap_pop();
         end
         if (heap_size > 0) ready_heap[0].remaining -= elapsed;
         sched_time += elapsed;
         if (heap_size >= DEPTH) begin
            o = '{it.task_id, 32'd0, RES_REJECT, 1'b0};
            res.push_back(o);
         end else begin
            e.task_id = it.task_id;
            e.arrival = it.arrival;
            e.remaining = it.run;
            e.prio = it.prio;
            heap_push(e);
         end
      end
      if (res.size() > 0) res[res.size() - 1].last = 1'b1;
      foreach (res[i]) awaited_results.push_back(res[i]);
   endtask

   task automatic add_item(logic act, logic [15:0] id, logic [31:0] arr, logic [31:0] run,
                           logic [7:0] pri);
      task_req_type it;
      it = '{act, id, arr, run, pri};
      pending_tasks.push_back(it);
   endtask

   // monitor: transfer acceptance and result checking
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
      took = !reset && start && !busy;
      if (took) begin
         schedule_item('{req_action, req_task_id, req_arrival_time, req_run_time,
                         req_priority_req});
      end
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result id %h fin %h st %b last %b", $time,
                     rsp_done_id, rsp_finish_time, rsp_status, rsp_last_result);
            errors++;
         end else begin
            outcome_type x;
            x = awaited_results.pop_front();
            if (x.id !== rsp_done_id || x.fin !== rsp_finish_time ||
                x.status !== rsp_status || x.last !== rsp_last_result) begin
               $display("%0t: expected id %h fin %h st %b last %b, got id %h fin %h st %b last %b",
                        $time, x.id, x.fin, x.status, x.last, rsp_done_id,
                        rsp_finish_time, rsp_status, rsp_last_result);
               errors++;
            end
         end
      end
   end

   // driver
   always @(negedge clock) begin
      int idle_pct;
      task_req_type it;
      idle_pct = (sent * 3 < total_items) ? 10 : (sent * 3 < total_items * 2) ? 54 : 0;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took) begin
         if (pending_tasks.size() > 0 && $urandom_range(99) >= idle_pct) begin
            it = pending_tasks.pop_front();
            req_action <= it.action;
            req_task_id <= it.task_id;
            req_arrival_time <= it.arrival;
            req_run_time <= it.run;
            req_priority_req <= it.prio;
            start <= 1'b1;
            sent++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   initial begin
      logic [31:0] t;
      int r;
      int bursts;
      t = 0;
      bursts = 0;
      add_item(ACT_DRAIN, 16'h0000, 32'd0, 32'd0, 8'd0);
      add_item(ACT_ARRIVE, 16'hFFFF, 32'd0, 32'd5, 8'd255);
      add_item(ACT_ARRIVE, 16'h0001, 32'd1, 32'd3, 8'd1);
      add_item(ACT_ARRIVE, 16'h0002, 32'd2, 32'd0, 8'd0);
      add_item(ACT_ARRIVE, 16'h0003, 32'd2, 32'd4, 8'd1);
      add_item(ACT_ARRIVE, 16'h0004, 32'd3, 32'd4, 8'd1);
      add_item(ACT_ARRIVE, 16'h0005, 32'd3, 32'd4, 8'd1);
      add_item(ACT_ARRIVE, 16'h0006, 32'd20, 32'd2, 8'd128);
      add_item(ACT_ARRIVE, 16'h0007, 32'd10, 32'd6, 8'd200);
      add_item(ACT_DRAIN, 16'h0000, 32'd0, 32'd0, 8'd0);
      add_item(ACT_ARRIVE, 16'h5A5A, 32'hFFFF_FFF0, 32'h40, 8'd7);
      add_item(ACT_ARRIVE, 16'hA5A5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
      add_item(ACT_ARRIVE, 16'h1234, 32'hFFFF_FFFF, 32'h8000_0000, 8'd254);
      add_item(ACT_DRAIN, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      add_item(ACT_ARRIVE, 16'h0008, 32'd5, 32'd1, 8'd9);
      add_item(ACT_DRAIN, 16'h0000, 32'd0, 32'd0, 8'd0);
      while (pending_tasks.size() < 430) begin
         r = $urandom_range(99);
         if (r < 5) begin
            add_item(ACT_DRAIN, 16'($urandom), $urandom, $urandom, 8'($urandom));
         end else if (r < 8 && bursts < 2) begin
            bursts++;
            t += $urandom_range(0, 10);
            repeat (67) add_item(ACT_ARRIVE, 16'($urandom), t, $urandom_range(1000, 5000),
                                 8'($urandom_range(1, 255)));
         end else begin
            if (r < 11) t += $urandom;
            else t += $urandom_range(0, 30);
            add_item(ACT_ARRIVE, 16'($urandom), (r < 20) ? t - $urandom_range(0, 40) : t,
                     (r < 25) ? $urandom : (r < 27) ? 32'd0 : $urandom_range(1, 40),
                     (r < 50) ? 8'($urandom_range(1, 4)) : 8'($urandom_range(0, 255)));
         end
      end
      add_item(ACT_DRAIN, 16'h0000, 32'd0, 32'd0, 8'd0);
      total_items = pending_tasks.size();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_tasks.size() > 0 || start || busy || awaited_results.size() > 0);
      repeat (400) @(posedge clock);
      if (errors == 0 && awaited_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire
